// ----- src/obmt_pkg.sv -----
// ---------------------------------------------------------------------------
// Ordered bigram match test package
// Shared widths, command codes and the scan microprogram.
// ---------------------------------------------------------------------------
package obmt_pkg;

   // Payload widths.
   localparam int CMD_W   = 3;
   localparam int CH_W    = 21;
   localparam int COUNT_W = 5;
   localparam int NEED_W  = 4;

   // Commands carried by a request beat.
   localparam logic [CMD_W-1:0] CMD_APPEND_ERR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND_CAND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_COMPARE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR_CAND  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR_ALL   = 3'd4;

   // Microprogram step addresses.
   typedef logic [1:0] step_type;
   localparam step_type STEP_INIT    = 2'd0;
   localparam step_type STEP_CHECK   = 2'd1;
   localparam step_type STEP_COMPARE = 2'd2;
   localparam step_type STEP_FINISH  = 2'd3;

   // Jump conditions.
   typedef logic [0:0] cond_type;
   localparam cond_type COND_NONE = 1'b0;
   localparam cond_type COND_END  = 1'b1;

   // One control word of the scan program.
   typedef struct packed {
      cond_type cond;    // condition that selects the jump target
      step_type jump;    // target when the condition holds
      step_type next;    // target otherwise
      logic     init;    // clear count and both pointers
      logic     compare; // test the fetched pairs and advance a pointer
      logic     finish;  // publish the result and stop
   } uword_type;

   // Scan program read-only table.
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w = '{cond: COND_NONE, jump: STEP_INIT, next: STEP_INIT,
            init: 1'b0, compare: 1'b0, finish: 1'b0};
      case (step)
         STEP_INIT: begin
            w.init = 1'b1;
            w.next = STEP_CHECK;
         end
         STEP_CHECK: begin
            // Stop when either word has no pair left at the pointers.
            w.cond = COND_END;
            w.jump = STEP_FINISH;
            w.next = STEP_COMPARE;
         end
         STEP_COMPARE: begin
            w.compare = 1'b1;
            w.next    = STEP_CHECK;
         end
         STEP_FINISH: begin
            w.finish = 1'b1;
            w.next   = STEP_FINISH;
         end
         default: begin
            w.next = STEP_INIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- src/obmt_word_store.sv -----
// ---------------------------------------------------------------------------
// Ordered bigram match test word store
// Character memory with one write port and two registered read ports.
// ---------------------------------------------------------------------------
module obmt_word_store #(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [obmt_pkg::CH_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [obmt_pkg::CH_W-1:0] rd_data_a,
   output logic [obmt_pkg::CH_W-1:0] rd_data_b
);
   import obmt_pkg::*;

   logic [CH_W-1:0] mem_ff [DEPTH];

   // Write one character.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Both reads are registered.
   always_ff @(posedge clock) begin
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ----- src/ordered_bigram_match_test_unit.sv -----
// ---------------------------------------------------------------------------
// Ordered bigram match test unit
// Loads an error word and a candidate word and tests ordered pair matches.
// ---------------------------------------------------------------------------
// Usage: each request beat carries a command and a character. Appends and
// clears produce no response. A compare beat starts a microcoded scan and
// yields one response beat with the accept flag, the match count, the
// needed count and the overflow flag.
// The scan runs a check and compare loop around the registered reads of
// the two word memories; each compare step tests one candidate pair
// position, and the scan makes at most about e + c steps for word
// lengths e and c.
// While a compare runs, req_stall is high. A response waits in its output
// register while rsp_stall is high; later loads and clears are still
// taken, and a following compare holds in its last step until the
// response register is free.
// Reset empties both words and clears the overflow flag; memory contents
// are undefined until written and need no clearing pass.
// ---------------------------------------------------------------------------
module ordered_bigram_match_test_unit #(
   parameter int MAX_WORD_LEN = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [obmt_pkg::CMD_W-1:0]    req_cmd,
   input  logic [obmt_pkg::CH_W-1:0]     req_ch,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic [obmt_pkg::COUNT_W-1:0]  rsp_match_count,
   output logic [obmt_pkg::NEED_W-1:0]   rsp_needed,
   output logic                          rsp_overflowed
);
   import obmt_pkg::*;

   localparam int AW = $clog2(MAX_WORD_LEN);
   localparam int LW = $clog2(MAX_WORD_LEN + 1);
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_WORD_LEN);
   localparam logic [LW-1:0] ONE     = LW'(1);

   // Word lengths and overflow flag.
   logic [LW-1:0] err_len_ff, err_len_in;
   logic [LW-1:0] cand_len_ff, cand_len_in;
   logic          dropped_ff, dropped_in;

   // Scan datapath registers.
   logic          busy_ff, busy_in;
   step_type      step_ff, step_in;
   logic [LW-1:0] err_idx_ff, err_idx_in;
   logic [LW-1:0] ptr_ff, ptr_in;
   logic [LW-1:0] count_ff, count_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_accepted_ff, rsp_accepted_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [NEED_W-1:0]  rsp_needed_ff, rsp_needed_in;
   logic               rsp_overflowed_ff, rsp_overflowed_in;

   uword_type     uword;
   logic          req_take;
   logic          rsp_take;
   logic          rsp_free;
   logic          cond_true;
   logic          pair_match;
   logic [LW-1:0] err_idx_p1;
   logic [LW-1:0] ptr_p1;
   logic [LW-1:0] needed;
   logic          err_wr;
   logic          cand_wr;
   logic [CH_W-1:0] err_a, err_b, cand_a, cand_b;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign err_idx_p1 = err_idx_ff + ONE;
   assign ptr_p1     = ptr_ff + ONE;

   // Append writes go to the next free entry when there is room.
   assign err_wr  = req_take && (req_cmd == CMD_APPEND_ERR) && (err_len_ff < MAX_LEN);
   assign cand_wr = req_take && (req_cmd == CMD_APPEND_CAND) && (cand_len_ff < MAX_LEN);

   obmt_word_store #(.DEPTH(MAX_WORD_LEN)) u_err_store (
      .clock     (clock),
      .wr_en     (err_wr),
      .wr_addr   (err_len_ff[AW-1:0]),
      .wr_data   (req_ch),
      .rd_addr_a (err_idx_ff[AW-1:0]),
      .rd_addr_b (err_idx_p1[AW-1:0]),
      .rd_data_a (err_a),
      .rd_data_b (err_b)
   );

   obmt_word_store #(.DEPTH(MAX_WORD_LEN)) u_cand_store (
      .clock     (clock),
      .wr_en     (cand_wr),
      .wr_addr   (cand_len_ff[AW-1:0]),
      .wr_data   (req_ch),
      .rd_addr_a (ptr_ff[AW-1:0]),
      .rd_addr_b (ptr_p1[AW-1:0]),
      .rd_data_a (cand_a),
      .rd_data_b (cand_b)
   );

   // Current control word and its jump condition.
   assign uword      = ucode_rom(step_ff);
   assign cond_true  = (uword.cond == COND_END) &&
                       ((err_idx_p1 >= err_len_ff) || (ptr_p1 >= cand_len_ff));
   assign pair_match = (cand_a == err_a) && (cand_b == err_b);

   // Required count is half of one less than the error length.
   assign needed = (err_len_ff == '0) ? '0 : ((err_len_ff - ONE) >> 1);

   // Command handling and word bookkeeping.
   always_comb begin
      err_len_in  = err_len_ff;
      cand_len_in = cand_len_ff;
      dropped_in  = dropped_ff;
      if (req_take) begin
         case (req_cmd)
            CMD_APPEND_ERR: begin
               if (err_len_ff < MAX_LEN) err_len_in = err_len_ff + ONE;
               else dropped_in = 1'b1;
            end
            CMD_APPEND_CAND: begin
               if (cand_len_ff < MAX_LEN) cand_len_in = cand_len_ff + ONE;
               else dropped_in = 1'b1;
            end
            CMD_CLEAR_CAND: begin
               cand_len_in = '0;
            end
            CMD_CLEAR_ALL: begin
               err_len_in  = '0;
               cand_len_in = '0;
               dropped_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer and scan datapath.
   always_comb begin
      busy_in           = busy_ff;
      step_in           = step_ff;
      err_idx_in        = err_idx_ff;
      ptr_in            = ptr_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_accepted_in   = rsp_accepted_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_needed_in     = rsp_needed_ff;
      rsp_overflowed_in = rsp_overflowed_ff;
      if (busy_ff) begin
         step_in = cond_true ? uword.jump : uword.next;
         if (uword.init) begin
            err_idx_in = '0;
            ptr_in     = '0;
            count_in   = '0;
         end
         if (uword.compare) begin
            if (pair_match) begin
               count_in   = count_ff + ONE;
               err_idx_in = err_idx_p1;
            end else begin
               ptr_in = ptr_p1;
            end
         end
         if (uword.finish) begin
            // Hold in this step until the response register frees up.
            if (rsp_free) begin
               busy_in           = 1'b0;
               step_in           = STEP_INIT;
               rsp_valid_in      = 1'b1;
               rsp_accepted_in   = count_ff >= needed;
               rsp_count_in      = COUNT_W'(count_ff);
               rsp_needed_in     = NEED_W'(needed);
               rsp_overflowed_in = dropped_ff;
            end
         end
      end else if (req_take && (req_cmd == CMD_COMPARE)) begin
         busy_in = 1'b1;
         step_in = STEP_INIT;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         err_len_ff   <= '0;
         cand_len_ff  <= '0;
         dropped_ff   <= 1'b0;
         busy_ff      <= 1'b0;
         step_ff      <= STEP_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         err_len_ff   <= err_len_in;
         cand_len_ff  <= cand_len_in;
         dropped_ff   <= dropped_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      err_idx_ff        <= err_idx_in;
      ptr_ff            <= ptr_in;
      count_ff          <= count_in;
      rsp_accepted_ff   <= rsp_accepted_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_needed_ff     <= rsp_needed_in;
      rsp_overflowed_ff <= rsp_overflowed_in;
   end

   assign req_stall       = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_needed      = rsp_needed_ff;
   assign rsp_overflowed  = rsp_overflowed_ff;

endmodule

// ----- tb/sv/ordered_bigram_match_test_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ordered bigram match test unit testbench
// Drives load, clear and compare beats into the unit with random idling on
// both channels. Each compare is scored by a scan model kept inside the
// bench, and every response beat is checked field by field, in order.
// A directed table covers the extremes and special cases, and random word
// pairs with small alphabets then exercise the scan deeply.
// ---------------------------------------------------------------------------
module ordered_bigram_match_test_unit_tb;
   import obmt_pkg::*;

   localparam int WORD_CAP     = 32;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 1260;
   localparam int PHASE_ITEMS  = 480;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PRINT_CAP    = 100;

   // Command codes that the unit ignores.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic               accepted;
      logic [COUNT_W-1:0] match_count;
      logic [NEED_W-1:0]  needed;
      logic               overflowed;
   } score_type;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [CH_W-1:0]  ch;
      int               reps;
      bit               typed;
      score_type        want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd = CMD_CLEAR_ALL;
   logic [CH_W-1:0]    req_ch = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_accepted;
   logic [COUNT_W-1:0] rsp_match_count;
   logic [NEED_W-1:0]  rsp_needed;
   logic               rsp_overflowed;

   // Scan model state.
   logic [CH_W-1:0] err_chars [WORD_CAP];
   logic [CH_W-1:0] cand_chars [WORD_CAP];
   logic [5:0]      err_len = '0;
   logic [5:0]      cand_len = '0;
   logic            chars_dropped = 1'b0;

   score_type pending_scores [$];
   int        mismatch_count = 0;
   int        item_count = 0;
   int        quiet_cycles = 0;
   int        sender_idle_pct = 14;
   int        receiver_idle_pct = 63;

   // Directed beats; only compares with an obvious outcome carry a typed score.
   stim_row_type directed_rows [26] = '{
      '{CMD_COMPARE,     21'h000000, 1,  1'b1, '{1'b1, 5'd0, 4'd0,  1'b0}},
      '{CMD_APPEND_ERR,  21'h000000, 1,  1'b0, '0},
      '{CMD_APPEND_ERR,  21'h1FFFFF, 1,  1'b0, '0},
      '{CMD_APPEND_ERR,  21'h10FFFF, 1,  1'b0, '0},
      '{CMD_APPEND_CAND, 21'h000000, 1,  1'b0, '0},
      '{CMD_APPEND_CAND, 21'h1FFFFF, 1,  1'b0, '0},
      '{CMD_COMPARE,     21'h000000, 1,  1'b0, '0},
      '{CMD_SPARE_LO,    21'h1FFFFF, 1,  1'b0, '0},
      '{CMD_SPARE_MID,   21'h000000, 1,  1'b0, '0},
      '{CMD_SPARE_HI,    21'h0AAAAA, 1,  1'b0, '0},
      '{CMD_COMPARE,     21'h155555, 1,  1'b0, '0},
      '{CMD_CLEAR_CAND,  21'h1FFFFF, 1,  1'b0, '0},
      '{CMD_COMPARE,     21'h000000, 1,  1'b0, '0},
      '{CMD_CLEAR_ALL,   21'h000000, 1,  1'b0, '0},
      '{CMD_APPEND_ERR,  21'h000041, 3,  1'b0, '0},
      '{CMD_APPEND_CAND, 21'h000041, 2,  1'b0, '0},
      '{CMD_COMPARE,     21'h000000, 1,  1'b0, '0},
      '{CMD_APPEND_CAND, 21'h155555, 31, 1'b0, '0},
      '{CMD_COMPARE,     21'h000000, 1,  1'b0, '0},
      '{CMD_CLEAR_CAND,  21'h000000, 1,  1'b0, '0},
      '{CMD_COMPARE,     21'h000000, 1,  1'b1, '{1'b0, 5'd0, 4'd1,  1'b1}},
      '{CMD_APPEND_ERR,  21'h0AAAAA, 30, 1'b0, '0},
      '{CMD_COMPARE,     21'h000000, 1,  1'b1, '{1'b0, 5'd0, 4'd15, 1'b1}},
      '{CMD_CLEAR_ALL,   21'h000000, 1,  1'b0, '0},
      '{CMD_APPEND_ERR,  21'h000007, 1,  1'b0, '0},
      '{CMD_COMPARE,     21'h000000, 1,  1'b1, '{1'b1, 5'd0, 4'd0,  1'b0}}
   };

   ordered_bigram_match_test_unit #(
      .MAX_WORD_LEN(WORD_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_ch(req_ch),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_accepted(rsp_accepted),
      .rsp_match_count(rsp_match_count),
      .rsp_needed(rsp_needed),
      .rsp_overflowed(rsp_overflowed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Greedy forward scan: one shared candidate pointer that never moves back.
   function automatic int count_ordered_pairs();
      int count;
      int ptr;
      count = 0;
      ptr = 0;
      for (int i = 0; i + 1 < err_len; i++) begin
         if (ptr + 1 >= cand_len) break;
         while (ptr + 1 < cand_len) begin
            if (cand_chars[ptr] == err_chars[i] && cand_chars[ptr + 1] == err_chars[i + 1]) begin
               count++;
               break;
            end
            ptr++;
         end
      end
      return count;
   endfunction

   // Applies one accepted request beat to the word stores and queues the score
   // that a compare must produce.
   task automatic score_request(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch);
      score_type s;
      int        count;
      int        need;
      case (cmd)
         CMD_APPEND_ERR: begin
            if (err_len < WORD_CAP) begin
               err_chars[err_len[4:0]] = ch;
               err_len++;
            end else begin
               chars_dropped = 1'b1;
            end
         end
         CMD_APPEND_CAND: begin
            if (cand_len < WORD_CAP) begin
               cand_chars[cand_len[4:0]] = ch;
               cand_len++;
            end else begin
               chars_dropped = 1'b1;
            end
         end
         CMD_COMPARE: begin
            count = count_ordered_pairs();
            need = (err_len > 0) ? (err_len - 1) / 2 : 0;
            s.accepted = (count >= need);
            s.match_count = count[COUNT_W-1:0];
            s.needed = need[NEED_W-1:0];
            s.overflowed = chars_dropped;
            pending_scores.push_back(s);
         end
         CMD_CLEAR_CAND: begin
            cand_len = '0;
         end
         CMD_CLEAR_ALL: begin
            err_len = '0;
            cand_len = '0;
            chars_dropped = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   // Presents one request beat after a random idle gap and waits until taken.
   task automatic drive_beat(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_cmd <= CMD_W'($urandom_range(CMD_SPARE_HI));
         req_ch <= CH_W'($urandom());
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_ch <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      score_request(cmd, ch);
      item_count++;
      // Idling phases: sender light and receiver heavy, then swapped, then none.
      if (item_count < PHASE_ITEMS) begin
         sender_idle_pct = 14;
         receiver_idle_pct = 63;
      end else if (item_count < 2 * PHASE_ITEMS) begin
         sender_idle_pct = 63;
         receiver_idle_pct = 14;
      end else begin
         sender_idle_pct = 0;
         receiver_idle_pct = 0;
      end
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Mostly short words, now and then long enough to fill a store.
   function automatic int pick_word_len();
      return ($urandom_range(9) == 0) ? $urandom_range(34, 9) : $urandom_range(8);
   endfunction

   // Either a tiny code point, so pairs repeat, or any 21-bit value.
   function automatic logic [CH_W-1:0] pick_symbol();
      logic [CH_W-1:0] c;
      if ($urandom_range(1) == 0) c = CH_W'($urandom_range(3));
      else c = CH_W'($urandom());
      return c;
   endfunction

   // Receiver stall, redrawn every cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // Response checker.
   always @(posedge clock) begin : check_scores
      score_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scores.size() == 0) begin
            flag_mismatch("response with no compare waiting", 1, 0);
         end else begin
            want = pending_scores.pop_front();
            if (rsp_accepted !== want.accepted)
               flag_mismatch("accepted", int'(rsp_accepted), int'(want.accepted));
            if (rsp_match_count !== want.match_count)
               flag_mismatch("match_count", int'(rsp_match_count), int'(want.match_count));
            if (rsp_needed !== want.needed)
               flag_mismatch("needed", int'(rsp_needed), int'(want.needed));
            if (rsp_overflowed !== want.overflowed)
               flag_mismatch("overflowed", int'(rsp_overflowed), int'(want.overflowed));
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ordered_bigram_match_test_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin
      logic [CH_W-1:0] alphabet [4];
      logic [CH_W-1:0] err_copy [WORD_CAP];
      int              copy_len;
      int              n_sym;
      int              word_len;
      int              cand_beats;
      int              pick;
      int              start_items;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table; typed rows replace the predicted score for that compare.
      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++)
            drive_beat(directed_rows[r].cmd, directed_rows[r].ch);
         if (directed_rows[r].typed)
            pending_scores[pending_scores.size() - 1] = directed_rows[r].want;
      end

      // Random part: mostly well-formed word pairs, some raw noise.
      start_items = item_count;
      while (item_count - start_items < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 85) begin
            n_sym = $urandom_range(4, 1);
            for (int k = 0; k < n_sym; k++) alphabet[k] = pick_symbol();
            if ($urandom_range(3) != 0) begin
               drive_beat(CMD_CLEAR_ALL, CH_W'($urandom()));
               word_len = pick_word_len();
               for (int k = 0; k < word_len; k++)
                  drive_beat(CMD_APPEND_ERR, alphabet[$urandom_range(n_sym - 1)]);
            end else begin
               // Keep the error word and try a fresh candidate against it.
               drive_beat(CMD_CLEAR_CAND, CH_W'($urandom()));
            end
            if ($urandom_range(1) == 0) begin
               // Candidate close to the error word: drops, swaps and inserts.
               copy_len = int'(err_len);
               for (int k = 0; k < copy_len; k++) err_copy[k] = err_chars[k];
               cand_beats = 0;
               for (int k = 0; k < copy_len && cand_beats < 34; k++) begin
                  pick = $urandom_range(9);
                  if (pick == 1) begin
                     drive_beat(CMD_APPEND_CAND, alphabet[$urandom_range(n_sym - 1)]);
                     cand_beats++;
                  end else if (pick != 0) begin
                     if (pick == 2) begin
                        drive_beat(CMD_APPEND_CAND, alphabet[$urandom_range(n_sym - 1)]);
                        cand_beats++;
                     end
                     drive_beat(CMD_APPEND_CAND, err_copy[k]);
                     cand_beats++;
                  end
               end
            end else begin
               word_len = pick_word_len();
               for (int k = 0; k < word_len; k++)
                  drive_beat(CMD_APPEND_CAND, alphabet[$urandom_range(n_sym - 1)]);
            end
            drive_beat(CMD_COMPARE, CH_W'($urandom()));
            if ($urandom_range(4) == 0) drive_beat(CMD_COMPARE, CH_W'($urandom()));
         end else begin
            pick = $urandom_range(6, 1);
            for (int k = 0; k < pick; k++)
               drive_beat(CMD_W'($urandom_range(CMD_SPARE_HI)), CH_W'($urandom()));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // Wait for every outstanding score, then let the unit settle.
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ordered_bigram_match_test_unit regression: pass");
      end else begin
         $display("ordered_bigram_match_test_unit regression: fail");
      end
      $finish;
   end

endmodule
